>>> hw/rtl/takf_pkg.sv
// Shared types, register codes and micro-program of the tilt angle Kalman filter.
package takf_pkg;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef logic [4:0] t_reg;

    localparam t_reg R_STEP   = 5'd0;
    localparam t_reg R_ANOISE = 5'd1;
    localparam t_reg R_BNOISE = 5'd2;
    localparam t_reg R_MNOISE = 5'd3;
    localparam t_reg R_OGAIN  = 5'd4;
    localparam t_reg R_ACCEL  = 5'd5;
    localparam t_reg R_GYRO   = 5'd6;
    localparam t_reg R_ZERO   = 5'd7;
    localparam t_reg R_ANG    = 5'd8;
    localparam t_reg R_BIAS   = 5'd9;
    localparam t_reg R_P00    = 5'd10;
    localparam t_reg R_P01    = 5'd11;
    localparam t_reg R_P10    = 5'd12;
    localparam t_reg R_P11    = 5'd13;
    localparam t_reg R_RATE   = 5'd14;
    localparam t_reg T_X      = 5'd16;
    localparam t_reg T_Y      = 5'd17;
    localparam t_reg T_Z      = 5'd18;
    localparam t_reg T_ERR    = 5'd19;
    localparam t_reg T_PCT0   = 5'd20;
    localparam t_reg T_PCT1   = 5'd21;
    localparam t_reg T_E      = 5'd22;
    localparam t_reg T_K0     = 5'd23;
    localparam t_reg T_K1     = 5'd24;
    localparam t_reg T_T1     = 5'd25;

    localparam int TMP_DEPTH = 10;

    localparam logic [2:0] CFG_STEP   = 3'd0;
    localparam logic [2:0] CFG_ANOISE = 3'd1;
    localparam logic [2:0] CFG_BNOISE = 3'd2;
    localparam logic [2:0] CFG_MNOISE = 3'd3;
    localparam logic [2:0] CFG_OGAIN  = 3'd4;

    typedef struct packed {
        t_op  op;
        t_reg dst;
        t_reg sa;
        t_reg sb;
    } t_uop;

    typedef logic [5:0] t_pc;
    localparam t_pc LAST_PC = 6'd33;

    function automatic t_uop uop(input t_pc pc);
        t_uop u;
        case (pc)
            6'd0:  u = '{OP_SUB, T_X,    R_GYRO,   R_BIAS};
            6'd1:  u = '{OP_MUL, T_X,    T_X,      R_STEP};
            6'd2:  u = '{OP_ADD, R_ANG,  R_ANG,    T_X};
            6'd3:  u = '{OP_SUB, T_Y,    R_ANOISE, R_P01};
            6'd4:  u = '{OP_SUB, T_Y,    T_Y,      R_P10};
            6'd5:  u = '{OP_SUB, T_Z,    R_ZERO,   R_P11};
            6'd6:  u = '{OP_MUL, T_Y,    T_Y,      R_STEP};
            6'd7:  u = '{OP_ADD, R_P00,  R_P00,    T_Y};
            6'd8:  u = '{OP_MUL, T_Z,    T_Z,      R_STEP};
            6'd9:  u = '{OP_ADD, R_P01,  R_P01,    T_Z};
            6'd10: u = '{OP_ADD, R_P10,  R_P10,    T_Z};
            6'd11: u = '{OP_MUL, T_Y,    R_BNOISE, R_STEP};
            6'd12: u = '{OP_ADD, R_P11,  R_P11,    T_Y};
            6'd13: u = '{OP_SUB, T_ERR,  R_ACCEL,  R_ANG};
            6'd14: u = '{OP_MUL, T_PCT0, R_OGAIN,  R_P00};
            6'd15: u = '{OP_MUL, T_PCT1, R_OGAIN,  R_P10};
            6'd16: u = '{OP_MUL, T_X,    R_OGAIN,  T_PCT0};
            6'd17: u = '{OP_ADD, T_E,    R_MNOISE, T_X};
            6'd18: u = '{OP_DIV, T_K0,   T_PCT0,   T_E};
            6'd19: u = '{OP_DIV, T_K1,   T_PCT1,   T_E};
            6'd20: u = '{OP_MUL, T_T1,   R_OGAIN,  R_P01};
            6'd21: u = '{OP_MUL, T_X,    T_K0,     T_PCT0};
            6'd22: u = '{OP_SUB, R_P00,  R_P00,    T_X};
            6'd23: u = '{OP_MUL, T_X,    T_K0,     T_T1};
            6'd24: u = '{OP_SUB, R_P01,  R_P01,    T_X};
            6'd25: u = '{OP_MUL, T_X,    T_K1,     T_PCT0};
            6'd26: u = '{OP_SUB, R_P10,  R_P10,    T_X};
            6'd27: u = '{OP_MUL, T_X,    T_K1,     T_T1};
            6'd28: u = '{OP_SUB, R_P11,  R_P11,    T_X};
            6'd29: u = '{OP_MUL, T_X,    T_K0,     T_ERR};
            6'd30: u = '{OP_ADD, R_ANG,  R_ANG,    T_X};
            6'd31: u = '{OP_MUL, T_X,    T_K1,     T_ERR};
            6'd32: u = '{OP_ADD, R_BIAS, R_BIAS,   T_X};
            6'd33: u = '{OP_SUB, R_RATE, R_GYRO,   R_BIAS};
            default: u = '{OP_ADD, T_X,  R_ZERO,   R_ZERO};
        endcase
        return u;
    endfunction

endpackage

>>> hw/rtl/takf_alu.sv
// Shared saturating add, subtract, multiply and divide unit.
module takf_alu #(
    parameter int W = 32,
    parameter int F = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  takf_pkg::t_alu_req    i_req,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic                  o_done,
    output logic signed [W-1:0]   o_res
);
    import takf_pkg::*;

    localparam int HB = (W + 1) / 2;
    localparam int NW = W + F;
    localparam int AW = (2 * W > NW) ? 2 * W : NW;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MLO  = 7'b0000010,
        S_MHI  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_RND  = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_ADD  = 7'b1000000
    } t_state;

    t_state                r_state;
    logic [W-1:0]          r_ua;
    logic [W-1:0]          r_ub;
    logic                  r_neg;
    logic                  r_isdiv;
    logic [AW-1:0]         r_acc;
    logic [NW-1:0]         r_num;
    logic [W-1:0]          r_rem;
    logic [CW-1:0]         r_cnt;
    logic signed [W-1:0]   r_res;

    logic [W-1:0]          ua;
    logic [W-1:0]          ub;
    logic signed [W:0]     sum;
    logic signed [W-1:0]   sum_sat;
    logic [W+HB-1:0]       p_lo;
    logic [2*W-HB-1:0]     p_hi;
    logic [W:0]            trial;
    logic                  ge;
    logic [W:0]            diff;
    logic [AW:0]           mag;
    logic [AW:0]           lim;
    logic [AW:0]           mag_c;

    always_comb begin
        ua = i_a[W-1] ? W'(-i_a) : W'(i_a);
        ub = i_b[W-1] ? W'(-i_b) : W'(i_b);
        if (i_req.op == OP_SUB) begin
            sum = {i_a[W-1], i_a} - {i_b[W-1], i_b};
        end else begin
            sum = {i_a[W-1], i_a} + {i_b[W-1], i_b};
        end
        if (sum[W] != sum[W-1]) begin
            sum_sat = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            sum_sat = sum[W-1:0];
        end
        p_lo  = r_ua * r_ub[HB-1:0];
        p_hi  = r_ua * r_ub[W-1:HB];
        trial = {r_rem, r_num[NW-1]};
        ge    = trial >= {1'b0, r_ub};
        diff  = trial - {1'b0, r_ub};
        if (r_isdiv) begin
            mag = {1'b0, r_acc};
        end else begin
            mag = ({1'b0, r_acc} + ((AW+1)'(1) << (F - 1))) >> F;
        end
        lim   = ((AW+1)'(1) << (W - 1)) - (AW+1)'(!r_neg);
        mag_c = (mag > lim) ? lim : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        unique case (i_req.op)
                            OP_ADD, OP_SUB: r_state <= S_ADD;
                            OP_MUL: r_state <= S_MLO;
                            OP_DIV: r_state <= (ub == '0) ? S_ADD : S_DIV;
                            default: r_state <= S_ADD;
                        endcase
                    end
                end
                S_ADD: r_state <= S_FIN;
                S_MLO: r_state <= S_MHI;
                S_MHI: r_state <= S_RND;
                S_DIV: begin
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: r_state <= S_FIN;
                S_FIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ua    <= ua;
                r_ub    <= ub;
                r_neg   <= i_a[W-1] ^ i_b[W-1];
                r_isdiv <= (i_req.op == OP_DIV);
                r_num   <= {ua, {F{1'b0}}};
                r_rem   <= '0;
                r_cnt   <= CW'(NW);
                r_acc   <= '0;
                r_res   <= (i_req.op == OP_DIV) ? '0 : sum_sat;
            end
            S_MLO: r_acc <= AW'(p_lo);
            S_MHI: r_acc <= r_acc + (AW'(p_hi) << HB);
            S_DIV: begin
                r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
                r_num <= {r_num[NW-2:0], ge};
                r_acc <= AW'({r_num[NW-2:0], ge});
                r_cnt <= r_cnt - CW'(1);
            end
            S_RND: r_res <= r_neg ? -$signed(mag_c[W-1:0]) : $signed(mag_c[W-1:0]);
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == S_FIN);
    assign o_res  = r_res;

endmodule

>>> hw/rtl/takf_seq.sv
// Micro-program sequencer with filter state and scratch registers.
module takf_seq #(
    parameter int W = 32,
    parameter int F = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [W-1:0]   i_accel,
    input  logic signed [W-1:0]   i_gyro,
    input  logic signed [W-1:0]   i_step,
    input  logic signed [W-1:0]   i_anoise,
    input  logic signed [W-1:0]   i_bnoise,
    input  logic signed [W-1:0]   i_mnoise,
    input  logic signed [W-1:0]   i_ogain,
    input  logic                  i_out_free,
    output logic                  o_busy,
    output logic                  o_done,
    output logic signed [W-1:0]   o_angle,
    output logic signed [W-1:0]   o_rate,
    output logic signed [W-1:0]   o_bias
);
    import takf_pkg::*;

    localparam logic signed [W-1:0] ONE =
        (F < W - 1) ? (W'(1) << F) : {1'b0, {(W-1){1'b1}}};

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_ISSUE = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state              r_state;
    t_pc                 r_pc;
    logic signed [W-1:0] r_accel;
    logic signed [W-1:0] r_gyro;
    logic signed [W-1:0] r_ang;
    logic signed [W-1:0] r_bias;
    logic signed [W-1:0] r_p00;
    logic signed [W-1:0] r_p01;
    logic signed [W-1:0] r_p10;
    logic signed [W-1:0] r_p11;
    logic signed [W-1:0] r_rate;
    logic signed [W-1:0] r_tmp [TMP_DEPTH];
    logic signed [W-1:0] r_opa;
    logic signed [W-1:0] r_opb;

    t_uop                u;
    t_alu_req            alu_req;
    logic                alu_done;
    logic signed [W-1:0] alu_res;

    function automatic logic signed [W-1:0] fixed_rd(input t_reg code);
        logic signed [W-1:0] v;
        unique case (code)
            R_STEP:   v = i_step;
            R_ANOISE: v = i_anoise;
            R_BNOISE: v = i_bnoise;
            R_MNOISE: v = i_mnoise;
            R_OGAIN:  v = i_ogain;
            R_ACCEL:  v = r_accel;
            R_GYRO:   v = r_gyro;
            R_ANG:    v = r_ang;
            R_BIAS:   v = r_bias;
            R_P00:    v = r_p00;
            R_P01:    v = r_p01;
            R_P10:    v = r_p10;
            R_P11:    v = r_p11;
            R_RATE:   v = r_rate;
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign u = uop(r_pc);

    always_comb begin
        alu_req.start = (r_state == S_ISSUE);
        alu_req.op    = u.op;
    end

    takf_alu #(.W(W), .F(F)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_pc    <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ:  r_state <= S_ISSUE;
                S_ISSUE: r_state <= S_WAIT;
                S_WAIT: begin
                    if (alu_done) begin
                        if (r_pc == LAST_PC) begin
                            r_state <= S_DONE;
                        end else begin
                            r_pc    <= r_pc + t_pc'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= '0;
            r_bias <= '0;
            r_p00  <= ONE;
            r_p01  <= '0;
            r_p10  <= '0;
            r_p11  <= ONE;
        end else if (r_state == S_WAIT && alu_done && !u.dst[4]) begin
            case (u.dst)
                R_ANG:   r_ang  <= alu_res;
                R_BIAS:  r_bias <= alu_res;
                R_P00:   r_p00  <= alu_res;
                R_P01:   r_p01  <= alu_res;
                R_P10:   r_p10  <= alu_res;
                R_P11:   r_p11  <= alu_res;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_accel <= i_accel;
            r_gyro  <= i_gyro;
        end
        if (r_state == S_WAIT && alu_done) begin
            if (u.dst[4]) begin
                r_tmp[u.dst[3:0]] <= alu_res;
            end else if (u.dst == R_RATE) begin
                r_rate <= alu_res;
            end
        end
        if (r_state == S_READ) begin
            r_opa <= u.sa[4] ? r_tmp[u.sa[3:0]] : fixed_rd(u.sa);
            r_opb <= u.sb[4] ? r_tmp[u.sb[3:0]] : fixed_rd(u.sb);
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = (r_state == S_DONE) && i_out_free;
    assign o_angle = r_ang;
    assign o_rate  = r_rate;
    assign o_bias  = r_bias;

endmodule

>>> hw/rtl/tilt_angle_kalman_filter.sv
// Top level of the tilt angle Kalman filter: handshakes, registers, result slot.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_accel_angle, i_gyro_rate
//   out      source     o_out_valid / i_out_stall o_angle_estimate, o_rate_estimate,
//                                                 o_bias_estimate
//   cfg      sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One item runs 34 micro-ops on one shared unit: 18 add/sub, 14 multiplies and 2
// bit-serial divides. The result is then handed to the output slot, and a new item is
// taken only once the sequencer is back in idle.
// Synchronous active-low reset restores the filter state and register defaults.
// A finished result waits in the output slot while the next item is taken; the
// sequencer holds at its end only while that slot is still full.
module tilt_angle_kalman_filter #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_accel_angle,
    input  logic signed [DATA_WIDTH-1:0] i_gyro_rate,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [DATA_WIDTH-1:0] o_angle_estimate,
    output logic signed [DATA_WIDTH-1:0] o_rate_estimate,
    output logic signed [DATA_WIDTH-1:0] o_bias_estimate,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_index,
    input  logic [31:0]                  i_cfg_data
);
    import takf_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int EW = (W > 33) ? W : 33;

    localparam logic signed [EW-1:0] VMAX = EW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);

    logic signed [W-1:0] r_step;
    logic signed [W-1:0] r_anoise;
    logic signed [W-1:0] r_bnoise;
    logic signed [W-1:0] r_mnoise;
    logic signed [W-1:0] r_ogain;
    logic                r_out_valid;
    logic signed [W-1:0] r_out_angle;
    logic signed [W-1:0] r_out_rate;
    logic signed [W-1:0] r_out_bias;

    logic signed [32:0]  cfg_raw;
    logic signed [EW-1:0] cfg_ext;
    logic signed [W-1:0] cfg_sat;
    logic                busy;
    logic                seq_done;
    logic                accept;
    logic signed [W-1:0] seq_angle;
    logic signed [W-1:0] seq_rate;
    logic signed [W-1:0] seq_bias;

    always_comb begin
        unique case (i_cfg_index)
            CFG_STEP, CFG_ANOISE, CFG_BNOISE: cfg_raw = {12'b0, i_cfg_data[20:0]};
            CFG_MNOISE: cfg_raw = {2'b0, i_cfg_data[30:0]};
            CFG_OGAIN:  cfg_raw = {i_cfg_data[31], i_cfg_data};
            default:    cfg_raw = '0;
        endcase
        cfg_ext = EW'(cfg_raw);
        if (cfg_ext > VMAX) begin
            cfg_sat = VMAX[W-1:0];
        end else if (cfg_ext < VMIN) begin
            cfg_sat = VMIN[W-1:0];
        end else begin
            cfg_sat = cfg_ext[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= W'(5243);
            r_anoise <= W'(1049);
            r_bnoise <= W'(3146);
            r_mnoise <= W'(524288);
            r_ogain  <= W'(1048576);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STEP:   r_step   <= cfg_sat;
                CFG_ANOISE: r_anoise <= cfg_sat;
                CFG_BNOISE: r_bnoise <= cfg_sat;
                CFG_MNOISE: r_mnoise <= cfg_sat;
                CFG_OGAIN:  r_ogain  <= cfg_sat;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    takf_seq #(.W(W), .F(FRAC_BITS)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_accel    (i_accel_angle),
        .i_gyro     (i_gyro_rate),
        .i_step     (r_step),
        .i_anoise   (r_anoise),
        .i_bnoise   (r_bnoise),
        .i_mnoise   (r_mnoise),
        .i_ogain    (r_ogain),
        .i_out_free (!r_out_valid),
        .o_busy     (busy),
        .o_done     (seq_done),
        .o_angle    (seq_angle),
        .o_rate     (seq_rate),
        .o_bias     (seq_bias)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out_angle <= seq_angle;
            r_out_rate  <= seq_rate;
            r_out_bias  <= seq_bias;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_angle_estimate = r_out_angle;
    assign o_rate_estimate  = r_out_rate;
    assign o_bias_estimate  = r_out_bias;

endmodule

>>> verif/takf_checker.sv
// Checker for the tilt angle Kalman filter: predicts each result and compares it.
module takf_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_accel_angle,
    input  logic signed [31:0] i_gyro_rate,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_angle_estimate,
    input  logic signed [31:0] i_rate_estimate,
    input  logic signed [31:0] i_bias_estimate,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import takf_pkg::*;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
        logic signed [31:0] bias;
    } t_estimate;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    longint step_time, angle_noise, bias_noise, measure_noise, observe_gain;
    longint angle_q, bias_q, p00, p01, p10, p11;
    t_estimate estimates_due[$];

    function automatic longint clamp(input logic signed [127:0] v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return longint'(v);
    endfunction

    function automatic longint q_add(input longint a, input longint b);
        logic signed [127:0] s;
        s = 128'(a) + 128'(b);
        return clamp(s);
    endfunction

    function automatic longint q_sub(input longint a, input longint b);
        logic signed [127:0] s;
        s = 128'(a) - 128'(b);
        return clamp(s);
    endfunction

    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] m;
        m = (128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b) + (128'd1 << 19)) >> 20;
        if (m > (128'd1 << 62)) m = 128'd1 << 62;
        return clamp(((a < 0) != (b < 0)) ? -$signed(m) : $signed(m));
    endfunction

    function automatic longint q_div(input longint a, input longint b);
        logic [127:0] m;
        if (b == 0) return 0;
        m = (128'(a < 0 ? -a : a) << 20) / 128'(b < 0 ? -b : b);
        if (m > (128'd1 << 62)) m = 128'd1 << 62;
        return clamp(((a < 0) != (b < 0)) ? -$signed(m) : $signed(m));
    endfunction

    task automatic filter_sample(input longint accel, input longint gyro);
        longint pd0, negp11, err, pct0, pct1, e, k0, k1, t1;
        t_estimate r;
        angle_q = q_add(angle_q, q_mul(q_sub(gyro, bias_q), step_time));
        pd0 = q_sub(q_sub(angle_noise, p01), p10);
        negp11 = clamp(-128'(p11));
        p00 = q_add(p00, q_mul(pd0, step_time));
        p01 = q_add(p01, q_mul(negp11, step_time));
        p10 = q_add(p10, q_mul(negp11, step_time));
        p11 = q_add(p11, q_mul(bias_noise, step_time));
        err = q_sub(accel, angle_q);
        pct0 = q_mul(observe_gain, p00);
        pct1 = q_mul(observe_gain, p10);
        e = q_add(measure_noise, q_mul(observe_gain, pct0));
        k0 = q_div(pct0, e);
        k1 = q_div(pct1, e);
        t1 = q_mul(observe_gain, p01);
        p00 = q_sub(p00, q_mul(k0, pct0));
        p01 = q_sub(p01, q_mul(k0, t1));
        p10 = q_sub(p10, q_mul(k1, pct0));
        p11 = q_sub(p11, q_mul(k1, t1));
        angle_q = q_add(angle_q, q_mul(k0, err));
        bias_q = q_add(bias_q, q_mul(k1, err));
        r.angle = angle_q[31:0];
        r.rate = 32'(q_sub(gyro, bias_q));
        r.bias = bias_q[31:0];
        estimates_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_time = 5243; angle_noise = 1049; bias_noise = 3146;
            measure_noise = 524288; observe_gain = 1048576;
            angle_q = 0; bias_q = 0; p00 = 1 << 20; p01 = 0; p10 = 0; p11 = 1 << 20;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STEP:   step_time = longint'(i_cfg_data[20:0]);
                    CFG_ANOISE: angle_noise = longint'(i_cfg_data[20:0]);
                    CFG_BNOISE: bias_noise = longint'(i_cfg_data[20:0]);
                    CFG_MNOISE: measure_noise = longint'(i_cfg_data[30:0]);
                    CFG_OGAIN:  observe_gain = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (estimates_due.size() == 0) begin
                    report_mismatch("unexpected item", i_angle_estimate, 0);
                end else begin
                    t_estimate w;
                    w = estimates_due.pop_front();
                    if (i_angle_estimate !== w.angle)
                        report_mismatch("angle", i_angle_estimate, w.angle);
                    if (i_rate_estimate !== w.rate)
                        report_mismatch("rate", i_rate_estimate, w.rate);
                    if (i_bias_estimate !== w.bias)
                        report_mismatch("bias", i_bias_estimate, w.bias);
                end
            end
            if (i_in_valid && !i_in_stall)
                filter_sample(i_accel_angle, i_gyro_rate);
        end
        o_pending = estimates_due.size();
    end
endmodule

>>> verif/tb_top.sv
// Testbench top for the tilt angle Kalman filter: stimulus, handshake pacing and verdict.
module tb_top;
    import takf_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd6;

    logic i_clk = 0, i_rst_n = 0;
    logic i_in_valid = 0, o_in_stall;
    logic signed [31:0] i_accel_angle = 0, i_gyro_rate = 0;
    logic o_out_valid, i_out_stall = 0;
    logic signed [31:0] o_angle_estimate, o_rate_estimate, o_bias_estimate;
    logic i_cfg_we = 0;
    logic [2:0] i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;
    int fail_count, pending, sender_idle_pct, receiver_idle_pct;
    longint cycle_count;

    tilt_angle_kalman_filter i_dut (.*);

    takf_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_accel_angle,
        .i_gyro_rate, .i_out_valid(o_out_valid), .i_out_stall, .i_angle_estimate(o_angle_estimate),
        .i_rate_estimate(o_rate_estimate), .i_bias_estimate(o_bias_estimate), .i_cfg_we,
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_field();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(200 << 20)) - (100 << 20));
        endcase
    endfunction

    task automatic send_sample(input logic [31:0] accel, input logic [31:0] gyro);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_accel_angle <= accel;
        i_gyro_rate <= gyro;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] st, input logic [31:0] an, input logic [31:0] bn,
                            input logic [31:0] mn, input logic [31:0] og);
        drain();
        write_reg(CFG_STEP, st);
        write_reg(CFG_ANOISE, an);
        write_reg(CFG_BNOISE, bn);
        write_reg(CFG_MNOISE, mn);
        write_reg(CFG_OGAIN, og);
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_we <= 0;
    endtask

    initial begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_sample(32'h7fffffff, 32'h80000000);
        send_sample(32'h80000000, 32'h7fffffff);
        send_sample(0, 0);
        send_sample(5 << 20, -(1 << 20));
        set_regs(0, 0, 0, 0, 0);
        send_sample(3 << 20, 1 << 20);
        send_sample(32'hffffffff, 32'hffffffff);
        set_regs(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h80000000);
        send_sample(32'h7fffffff, 32'h7fffffff);
        send_sample(32'h80000000, 32'h80000000);
        set_regs(1048576, 1048576, 1048576, 1, 32'h7fffffff);
        send_sample(1 << 20, 2 << 20);
        send_sample(-(1 << 20), 32'h55555555);
        set_regs(5243, 1049, 3146, 524288, -(1 << 20));
        send_sample(7 << 20, 32'haaaaaaaa);
        for (int i = 0; i < 950; i++) begin
            if (i % 160 == 0) begin
                set_regs($urandom_range(1, 1 << 20), $urandom_range(1 << 20),
                         $urandom_range(1 << 20), $urandom_range(1, 32'h7fffffff),
                         (i % 320 == 0) ? $urandom : 32'($signed($urandom_range(4 << 20)) - (2 << 20)));
            end
            sender_idle_pct = i < 320 ? 22 : (i < 640 ? 72 : 0);
            receiver_idle_pct = i < 320 ? 72 : (i < 640 ? 22 : 0);
            send_sample(pick_field(), pick_field());
        end
        drain();
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
